>>> rtl/core/plap_pkg.sv
`default_nettype none
package plap_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W = 6;
  localparam logic [31:0] MIN_SEG_RESET = 32'd1;
  localparam logic REG_MIN_SEG_LEN = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2,
    ST_FEW   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DECODE,
    OP_ABSDIFF,
    OP_SQUARE,
    OP_SUM,
    OP_SQRT_STEP,
    OP_STORE,
    OP_CLAMP,
    OP_RD_MID,
    OP_SEARCH,
    OP_INDEX,
    OP_RD_I0,
    OP_RD_I1,
    OP_SETUP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_FINISH,
    OP_PUBLISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_DIFF,
    S_SQUARE,
    S_SUM,
    S_SQRT,
    S_CHECK,
    S_TOTAL,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_INDEX,
    S_RD0,
    S_RD1,
    S_SETUP,
    S_DIV_CHK,
    S_DIV,
    S_MUL,
    S_FINISH,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic empty;
    logic few;
    logic search_go;
    logic div_trivial;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/plap_if.sv
`default_nettype none
interface plap_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               restart;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic        [39:0] query_s;

  modport source(output valid, action, restart, vertex_x, vertex_y, query_s, input ready);
  modport sink(input valid, action, restart, vertex_x, vertex_y, query_s, output ready);
endinterface

interface plap_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic        [7:0]  segment_index;
  logic        [39:0] arc_s;

  modport source(output valid, status, point_x, point_y, segment_index, arc_s, input ready);
  modport sink(input valid, status, point_x, point_y, segment_index, arc_s, output ready);
endinterface
`default_nettype wire

>>> rtl/core/plap_ctrl.sv
`default_nettype none
module plap_ctrl import plap_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        if (stat.is_query) begin
          state_next = stat.few ? S_DONE : S_TOTAL;
        end else begin
          state_next = (stat.full || stat.empty) ? S_DONE : S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op     = OP_ABSDIFF;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.op     = OP_SQUARE;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        step_next  = STEP_W'(SQRT_STEPS - 1);
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op    = OP_SQRT_STEP;
        step_next = step - 1'b1;
        if (step == '0) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = OP_STORE;
        state_next = S_DONE;
      end
      S_TOTAL: begin
        cmd.op     = OP_CLAMP;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.search_go) begin
          cmd.op     = OP_RD_MID;
          state_next = S_SRCH_CMP;
        end else begin
          cmd.op     = OP_INDEX;
          state_next = S_RD0;
        end
      end
      S_SRCH_CMP: begin
        cmd.op     = OP_SEARCH;
        state_next = S_SRCH_CHK;
      end
      S_INDEX: begin
        cmd.op     = OP_INDEX;
        state_next = S_RD0;
      end
      S_RD0: begin
        cmd.op     = OP_RD_I0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.op     = OP_RD_I1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.op     = OP_SETUP;
        state_next = S_DIV_CHK;
      end
      S_DIV_CHK: begin
        cmd.op     = OP_DIV_INIT;
        step_next  = STEP_W'(DIV_STEPS - 1);
        state_next = stat.div_trivial ? S_MUL : S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV_STEP;
        step_next = step - 1'b1;
        if (step == '0) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/plap_dpath.sv
`default_nettype none
module plap_dpath import plap_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic               in_action,
  input  wire logic               in_restart,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic        [39:0] in_query_s,
  input  wire logic        [31:0] min_segment_length,
  plap_out_if.source              rsp
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = AW + 1;

  // vertex store, one write and one registered read per cycle
  logic [31:0] mem_x   [MAX_VERTICES];
  logic [31:0] mem_y   [MAX_VERTICES];
  logic [39:0] mem_arc [MAX_VERTICES];
  logic [31:0] rd_x, rd_y;
  logic [39:0] rd_arc;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [39:0]   wr_arc;

  logic [CW-1:0] cnt;
  logic          act;
  logic [31:0]   vx, vy;
  logic [39:0]   qs;

  // load path
  logic [31:0] ax, ay;
  logic [63:0] sx, sy;
  logic [65:0] rad;
  logic [35:0] rem_sq;
  logic [32:0] root;
  logic [39:0] prev_arc;

  // query path
  logic [39:0]   s_pos, a0, den, num;
  logic [CW-1:0] lo, hi;
  logic [AW-1:0] i0;
  logic [31:0]   x0, y0, magx, magy;
  logic          posx, posy;
  logic [40:0]   rem_dv;
  logic [32:0]   ratio;
  logic [64:0]   prodx, prody;

  // result being built, and result on offer
  status_t     res_status;
  logic [31:0] res_px, res_py;
  logic [7:0]  res_seg;
  logic [39:0] res_arc;
  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_px, out_py;
  logic [7:0]  out_seg;
  logic [39:0] out_arc;

  logic [CW-1:0] cnt_m1, mid, lo_m1, lim;
  logic [32:0]   dxw, dyw, ux, uy;
  logic [35:0]   rem_sh, trial;
  logic          sq_ge, is_short;
  logic [40:0]   arc_sum, dv_sh;
  logic [39:0]   arc_sat;
  logic [65:0]   rndx, rndy;
  logic [31:0]   offx, offy;

  assign cnt_m1   = cnt - 1'b1;
  assign mid      = lo + ((hi - lo) >> 1);
  assign lo_m1    = (lo == '0) ? '0 : lo - 1'b1;
  assign lim      = cnt - CW'(2);

  assign dxw      = {vx[31], vx} - {rd_x[31], rd_x};
  assign dyw      = {vy[31], vy} - {rd_y[31], rd_y};
  assign ux       = {rd_x[31], rd_x} - {x0[31], x0};
  assign uy       = {rd_y[31], rd_y} - {y0[31], y0};

  assign rem_sh   = {rem_sq[33:0], rad[65:64]};
  assign trial    = {1'b0, root, 2'b01};
  assign sq_ge    = rem_sh >= trial;

  assign is_short = root < {1'b0, min_segment_length};
  assign arc_sum  = {1'b0, prev_arc} + 41'(root);
  assign arc_sat  = arc_sum[40] ? '1 : arc_sum[39:0];

  assign dv_sh    = {rem_dv[39:0], 1'b0};
  assign rndx     = {1'b0, prodx} + 66'h0_8000_0000;
  assign rndy     = {1'b0, prody} + 66'h0_8000_0000;
  assign offx     = rndx[63:32];
  assign offy     = rndy[63:32];

  assign stat.is_query    = act;
  assign stat.full        = cnt >= CW'(MAX_VERTICES);
  assign stat.empty       = cnt == '0;
  assign stat.few         = cnt < CW'(2);
  assign stat.search_go   = lo < hi;
  assign stat.div_trivial = (den == '0) || (num >= den);
  assign stat.out_busy    = out_valid && !rsp.ready;

  always_comb begin
    unique case (cmd.op)
      OP_RD_MID: rd_addr = mid[AW-1:0];
      OP_RD_I0:  rd_addr = i0;
      OP_RD_I1:  rd_addr = i0 + 1'b1;
      default:   rd_addr = cnt_m1[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_arc  = '0;
    if (cmd.op == OP_DECODE && !act && cnt == '0) begin
      wr_en = 1'b1;
    end else if (cmd.op == OP_STORE && !is_short) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_arc  = arc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr]   <= vx;
      mem_y[wr_addr]   <= vy;
      mem_arc[wr_addr] <= wr_arc;
    end
    rd_x   <= mem_x[rd_addr];
    rd_y   <= mem_y[rd_addr];
    rd_arc <= mem_arc[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.op == OP_LATCH && !in_action && in_restart) begin
      cnt <= '0;
    end else if (wr_en) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        act        <= in_action;
        vx         <= in_vertex_x;
        vy         <= in_vertex_y;
        qs         <= in_query_s;
        res_status <= ST_OK;
        res_px     <= '0;
        res_py     <= '0;
        res_seg    <= '0;
        res_arc    <= '0;
      end
      OP_DECODE: begin
        if (act && stat.few) res_status <= ST_FEW;
        else if (!act && stat.full) res_status <= ST_FULL;
      end
      OP_ABSDIFF: begin
        ax       <= dxw[32] ? 32'(-dxw) : dxw[31:0];
        ay       <= dyw[32] ? 32'(-dyw) : dyw[31:0];
        prev_arc <= rd_arc;
      end
      OP_SQUARE: begin
        sx <= ax * ax;
        sy <= ay * ay;
      end
      OP_SUM: begin
        rad    <= {2'b00, sx} + {2'b00, sy};
        rem_sq <= '0;
        root   <= '0;
      end
      OP_SQRT_STEP: begin
        rad    <= {rad[63:0], 2'b00};
        rem_sq <= sq_ge ? rem_sh - trial : rem_sh;
        root   <= {root[31:0], sq_ge};
      end
      OP_STORE: begin
        if (is_short) res_status <= ST_SHORT;
        else res_arc <= arc_sat;
      end
      OP_CLAMP: begin
        s_pos <= (qs > rd_arc) ? rd_arc : qs;
        lo    <= '0;
        hi    <= cnt;
      end
      OP_SEARCH: begin
        if (rd_arc > s_pos) hi <= mid;
        else lo <= mid + 1'b1;
      end
      OP_INDEX: begin
        i0 <= (lo_m1 > lim) ? lim[AW-1:0] : lo_m1[AW-1:0];
      end
      OP_RD_I1: begin
        a0 <= rd_arc;
        x0 <= rd_x;
        y0 <= rd_y;
      end
      OP_SETUP: begin
        den  <= rd_arc - a0;
        num  <= (s_pos > a0) ? s_pos - a0 : '0;
        magx <= ux[32] ? 32'(-ux) : ux[31:0];
        magy <= uy[32] ? 32'(-uy) : uy[31:0];
        posx <= !ux[32];
        posy <= !uy[32];
      end
      OP_DIV_INIT: begin
        ratio  <= stat.div_trivial ? 33'h1_0000_0000 : '0;
        rem_dv <= {1'b0, num};
      end
      OP_DIV_STEP: begin
        if (dv_sh >= {1'b0, den}) begin
          rem_dv <= dv_sh - {1'b0, den};
          ratio  <= {ratio[31:0], 1'b1};
        end else begin
          rem_dv <= dv_sh;
          ratio  <= {ratio[31:0], 1'b0};
        end
      end
      OP_MUL: begin
        prodx <= magx * ratio;
        prody <= magy * ratio;
      end
      OP_FINISH: begin
        res_px  <= posx ? x0 + offx : x0 - offx;
        res_py  <= posy ? y0 + offy : y0 - offy;
        res_seg <= 8'(i0);
        res_arc <= s_pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUBLISH) begin
      out_status <= res_status;
      out_px     <= res_px;
      out_py     <= res_py;
      out_seg    <= res_seg;
      out_arc    <= res_arc;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.point_x       = out_px;
  assign rsp.point_y       = out_py;
  assign rsp.segment_index = out_seg;
  assign rsp.arc_s         = out_arc;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_VERTICES))
    else $error("vertex count above store depth");

  a_search_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SEARCH |-> lo < hi)
    else $error("search step with empty range");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUBLISH |-> !(out_valid && !rsp.ready))
    else $error("result overwritten while on offer");

  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FEW |-> out_arc == '0 && out_seg == '0)
    else $error("short-store query carries data");

endmodule
`default_nettype wire

>>> rtl/core/polyline_arc_length_point_top.sv
`default_nettype none
// channel  dir  handshake       payload
// req      in   valid/ready     action, restart, vertex_x, vertex_y, query_s
// rsp      out  valid/ready     status, point_x, point_y, segment_index, arc_s
// apb      in   psel/penable    min_segment_length at byte address 0
//
// One item at a time. A vertex load with a segment runs the 33-step square
// root; a first vertex, a full store or a query on too few vertices goes
// straight from decode to its result. A query runs the search reads of the
// arc memory and the 32-step divider, which it skips when the position sits
// at a segment end. A result waiting on rsp stalls the next one.
// Reset (rst, synchronous) empties the store and sets the minimum length to 1.
// A new item is taken while the previous result still waits on rsp.
module polyline_arc_length_point_top import plap_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  plap_in_if.sink          req,
  plap_out_if.source       rsp
);

  logic [31:0] min_seg;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        in_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_SEG_LEN) ? min_seg : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seg <= MIN_SEG_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_SEG_LEN) begin
      min_seg <= pwdata;
    end
  end

  assign req.ready = in_ready;

  plap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plap_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (req.action),
    .in_restart         (req.restart),
    .in_vertex_x        (req.vertex_x),
    .in_vertex_y        (req.vertex_y),
    .in_query_s         (req.query_s),
    .min_segment_length (min_seg),
    .rsp                (rsp)
  );

endmodule
`default_nettype wire

>>> tb/tb_polyline_arc_length_point_top.sv
module tb_polyline_arc_length_point_top;
  import plap_pkg::*;

  typedef struct packed {
    logic        action;
    logic        restart;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [39:0] qs;
  } vtx_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] px;
    logic [31:0] py;
    logic [7:0]  seg;
    logic [39:0] arc;
  } point_res_t;

  localparam int NV = MAX_VERTICES_DEF;
  localparam logic [39:0] ARC_MAX = 40'hFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  plap_in_if req ();
  plap_out_if rsp ();

  polyline_arc_length_point_top i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] pv_x [NV];
  logic [31:0] pv_y [NV];
  logic [39:0] pv_arc [NV];
  int unsigned pv_count;
  logic [31:0] min_len;

  vtx_item_t pending_items[$];
  point_res_t expected_points[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit hold_send = 0;

  function automatic logic [65:0] sq_len(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         logic [31:0] d);
    logic signed [32:0] dx, dy;
    logic [65:0] sx, sy;
    dx = $signed({a[31], a}) - $signed({c[31], c});
    dy = $signed({b[31], b}) - $signed({d[31], d});
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sx = 66'(dx[31:0]) * 66'(dx[31:0]);
    sy = 66'(dy[31:0]) * 66'(dy[31:0]);
    if (dx[32]) sx = 66'(dx) * 66'(dx);
    if (dy[32]) sy = 66'(dy) * 66'(dy);
    return sx + sy;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [65:0] v);
    logic [67:0] rem, trial;
    logic [63:0] root;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'((v >> (2 * i)) & 66'd3);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [32:0] ratio);
    logic signed [33:0] sa, sb, res;
    logic [32:0] mag;
    logic [65:0] off;
    sa = $signed(a);
    sb = $signed(b);
    mag = (sb >= sa) ? 33'(sb - sa) : 33'(sa - sb);
    off = (66'(mag) * 66'(ratio) + 66'h8000_0000) >> 32;
    res = (sb >= sa) ? sa + $signed(34'(off)) : sa - $signed(34'(off));
    return res[31:0];
  endfunction

  function automatic point_res_t compute_point(vtx_item_t it);
    point_res_t r;
    r = '0;
    if (!it.action) begin
      if (it.restart) pv_count = 0;
      if (pv_count >= NV) begin
        r.status = ST_FULL;
      end else if (pv_count == 0) begin
        pv_x[0] = it.vx;
        pv_y[0] = it.vy;
        pv_arc[0] = 0;
        pv_count = 1;
      end else begin
        logic [63:0] len;
        logic [64:0] acc;
        len = int_sqrt(sq_len(it.vx, it.vy, pv_x[pv_count-1], pv_y[pv_count-1]));
        if (len < 64'(min_len)) begin
          r.status = ST_SHORT;
        end else begin
          acc = 65'(pv_arc[pv_count-1]) + 65'(len);
          if (acc > 65'(ARC_MAX)) acc = 65'(ARC_MAX);
          pv_x[pv_count] = it.vx;
          pv_y[pv_count] = it.vy;
          pv_arc[pv_count] = acc[39:0];
          pv_count++;
          r.arc = acc[39:0];
        end
      end
    end else if (pv_count < 2) begin
      r.status = ST_FEW;
    end else begin
      logic [39:0] s, den, num;
      logic [32:0] ratio;
      logic [40:0] rem;
      int unsigned lo, hi, mid, i0;
      s = (it.qs > pv_arc[pv_count-1]) ? pv_arc[pv_count-1] : it.qs;
      lo = 0;
      hi = pv_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (pv_arc[mid] > s) hi = mid;
        else lo = mid + 1;
      end
      i0 = (lo == 0) ? 0 : lo - 1;
      if (i0 > pv_count - 2) i0 = pv_count - 2;
      den = pv_arc[i0+1] - pv_arc[i0];
      num = (s > pv_arc[i0]) ? s - pv_arc[i0] : 0;
      if (den == 0 || num >= den) begin
        ratio = 33'h1_0000_0000;
      end else begin
        rem = 41'(num);
        ratio = 0;
        for (int k = 0; k < 32; k++) begin
          rem = rem << 1;
          ratio = ratio << 1;
          if (rem >= 41'(den)) begin
            rem = rem - 41'(den);
            ratio[0] = 1'b1;
          end
        end
      end
      r.px = lerp(pv_x[i0], pv_x[i0+1], ratio);
      r.py = lerp(pv_y[i0], pv_y[i0+1], ratio);
      r.seg = i0[7:0];
      r.arc = s;
    end
    return r;
  endfunction

  // driver: bursts and gaps; an item stays on the bus until it is accepted
  int burst_left = 0, gap_left = 0;
  int unsigned n_sent = 0, n_taken = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && n_taken != n_sent) begin
      // hold
    end else begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if (pending_items.size() != 0 && !hold_send) begin
        vtx_item_t it;
        it = pending_items[0];
        n_sent <= n_sent + 1;
        req.valid <= 1'b1;
        {req.action, req.restart, req.vertex_x, req.vertex_y, req.query_s} <= it;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // an item leaves the queue at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      expected_points.insert(expected_points.size(), compute_point(pending_items.pop_front()));
      n_taken <= n_taken + 1;
    end
  end

  // receiver stall pattern
  logic [7:0] stall_pat = 8'b1011_0111;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      stall_pat <= {stall_pat[6:0], stall_pat[7]};
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= stall_pat[7];
        default: rsp.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      point_res_t got, exp_r;
      got = {rsp.status, rsp.point_x, rsp.point_y, rsp.segment_index, rsp.arc_s};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_points.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %h %0d %h  got %0d %h %h %0d %h",
                     exp_r.status, exp_r.px, exp_r.py, exp_r.seg, exp_r.arc,
                     got.status, got.px, got.py, got.seg, got.arc);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_arc_length_point_top regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || req.valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_min_len(logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    min_len = v;
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
    endcase
  endfunction

  task automatic add(logic act, logic rs, logic [31:0] x, logic [31:0] y, logic [39:0] q);
    vtx_item_t it;
    it = '{act, rs, x, y, q};
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [39:0] rnd_q();
    case ($urandom_range(0, 3))
      0: return 40'({$urandom(), $urandom()});
      1: return 0;
      default: return 40'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 8);
    endcase
  endfunction

  initial begin
    int n;
    min_len = MIN_SEG_RESET;
    pv_count = 0;
    req.valid = 0; req.action = 0; req.restart = 0;
    req.vertex_x = 0; req.vertex_y = 0; req.query_s = 0;
    rsp.ready = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: few vertices, extremes, short segment, query clamping, zero length
    add(1, 0, 0, 0, 0);
    add(0, 1, 32'h8000_0000, 32'h8000_0000, 0);
    add(1, 1, 0, 0, ARC_MAX);
    add(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    add(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    add(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add(1, 0, 0, 0, 0);
    add(1, 0, 0, 0, ARC_MAX);
    add(1, 0, 0, 0, 40'h1_2345_6789);
    add(0, 1, 0, 0, 0);
    add(0, 0, 32'h0001_0000, 0, 0);
    add(0, 0, 32'h0001_0000, 32'hFFFF_0000, 0);
    add(1, 0, 0, 0, 40'h0_8000);
    add(1, 0, 0, 0, 40'h1_8000);
    add(1, 0, 0, 0, 40'h1_0000);
    wait_idle();
    write_min_len(0);
    add(0, 1, 5, 5, 0);
    add(0, 0, 5, 5, 0);
    add(0, 0, 32'h0003_0000, 32'h0004_0000, 0);
    add(1, 0, 0, 0, 0);
    add(1, 0, 0, 0, 40'h2_0000);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_min_len(32'hFFFF_FFFF);
        1: write_min_len(32'h0001_0000);
        2: write_min_len(0);
        3: write_min_len($urandom_range(0, 32'h0100_0000));
        default: write_min_len(1);
      endcase
      n = 0;
      while (n < 360) begin
        int mode, len;
        mode = $urandom_range(0, 2);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 300) : $urandom_range(2, 20);
        add(0, 1, rnd_coord(mode), rnd_coord(mode), rnd_q());
        for (int k = 1; k < len; k++) add(0, $urandom_range(0, 40) == 0, rnd_coord(mode),
                                          rnd_coord(mode), rnd_q());
        n += len;
        for (int k = 0; k < $urandom_range(1, 10); k++) begin
          add(1, $urandom_range(0, 1), $urandom(), $urandom(), rnd_q());
          n++;
        end
      end
      if (ph == 2) begin
        while (pending_items.size() != 0 || req.valid) @(posedge clk);
        hold_send = 1;
        while (expected_points.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      wait_idle();
    end
    stim_done = 1;
    if (mismatches == 0) begin
      $display("polyline_arc_length_point_top regression: pass");
    end else begin
      $display("polyline_arc_length_point_top regression: fail");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/plap_pkg.sv
rtl/core/plap_if.sv
rtl/core/plap_ctrl.sv
rtl/core/plap_dpath.sv
rtl/core/polyline_arc_length_point_top.sv
tb/tb_polyline_arc_length_point_top.sv
